// ----- sv/cnd_pkg.sv -----
// Shared types, constants and functions of the cpio newc stream deframer.
`default_nettype none
package cnd_pkg;

  localparam int unsigned ENTRY_COUNT_BITS_DEF = 16;

  localparam int unsigned HEADER_BYTES = 110;
  localparam int unsigned HEX_DIGITS   = 8;

  localparam logic [6:0] FS_FIRST = 7'd54;
  localparam logic [6:0] FS_LAST  = 7'(54 + HEX_DIGITS - 1);
  localparam logic [6:0] NS_FIRST = 7'd94;
  localparam logic [6:0] NS_LAST  = 7'(94 + HEX_DIGITS - 1);
  localparam logic [6:0] HDR_LAST = 7'(HEADER_BYTES - 1);
  localparam logic [1:0] HDR_OFFSET = 2'(HEADER_BYTES % 4);

  localparam logic [3:0] TRAILER_LEN = 4'd10;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_DATA,
    PH_DATA_PAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] entry_number;
    logic [31:0] file_size;
    logic        last_of_field;
  } res_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      d = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      d = 4'(c - 8'h57);
    end
    return d;
  endfunction

  // "TRAILER!!!"
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = 8'h54;
      4'd1: c = 8'h52;
      4'd2: c = 8'h41;
      4'd3: c = 8'h49;
      4'd4: c = 8'h4C;
      4'd5: c = 8'h45;
      4'd6: c = 8'h52;
      4'd7: c = 8'h21;
      4'd8: c = 8'h21;
      4'd9: c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cnd_stream_if.sv -----
// Valid/ready channel interfaces for archive bytes and deframed results.
`default_nettype none
interface cnd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink (input valid, input archive_byte, output ready);
endinterface

interface cnd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [15:0] entry_number;
  logic [31:0] file_size;
  logic        last_of_field;

  modport source (output valid, output kind, output byte_value, output entry_number,
                  output file_size, output last_of_field, input ready);
  modport sink (input valid, input kind, input byte_value, input entry_number,
                input file_size, input last_of_field, output ready);
endinterface
`default_nettype wire

// ----- sv/cnd_in_stage.sv -----
// Input register that holds one archive byte beat.
`default_nettype none
module cnd_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  cnd_byte_if.sink    in_bus,
  input  logic        take,
  output logic        byte_valid,
  output logic [7:0]  byte_val
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       accept;

  assign in_bus.ready = !valid_r || take;
  assign accept       = in_bus.valid && in_bus.ready;
  assign byte_valid   = valid_r;
  assign byte_val     = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_bus.archive_byte;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cnd_parse.sv -----
// Header decode, field tracking and trailer detection, one byte per cycle while fire is high.
`default_nettype none
module cnd_parse import cnd_pkg::*; #(
  parameter int unsigned ENTRY_COUNT_BITS = ENTRY_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] b,
  output logic       res_valid,
  output res_t       res
);

  phase_t                      phase_r, phase_nxt;
  logic [6:0]                  hpos_r, hpos_nxt;
  logic [31:0]                 name_len_r, name_len_nxt;
  logic [31:0]                 data_len_r, data_len_nxt;
  logic [31:0]                 left_r, left_nxt;
  logic [1:0]                  off_r, off_nxt;
  logic                        tmatch_r, tmatch_nxt;
  logic [3:0]                  idx_r, idx_nxt;
  logic [ENTRY_COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [3:0]  hex_val;
  logic [31:0] name_base, data_base;
  logic [31:0] left_dec;
  logic [1:0]  off_inc, pad_after;
  logic        last_byte;
  logic        trailer_end;
  logic [31:0] cnt_wide;
  logic        start_data, finish_entry;

  assign hex_val     = hex_digit(b);
  assign name_base   = (hpos_r == 7'd0) ? 32'd0 : name_len_r;
  assign data_base   = (hpos_r == 7'd0) ? 32'd0 : data_len_r;
  assign left_dec    = left_r - 32'd1;
  assign off_inc     = off_r + 2'd1;
  assign pad_after   = 2'd0 - off_inc;
  assign last_byte   = (left_r == 32'd1);
  assign trailer_end = tmatch_r && (idx_r == TRAILER_LEN) && (b == 8'd0);
  assign cnt_wide    = 32'(cnt_r);

  always_comb begin : next_state
    phase_nxt    = phase_r;
    hpos_nxt     = hpos_r;
    name_len_nxt = name_len_r;
    data_len_nxt = data_len_r;
    left_nxt     = left_r;
    off_nxt      = off_r;
    tmatch_nxt   = tmatch_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    start_data   = 1'b0;
    finish_entry = 1'b0;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          name_len_nxt = (hpos_r inside {[NS_FIRST:NS_LAST]}) ?
                         {name_base[27:0], hex_val} : name_base;
          data_len_nxt = (hpos_r inside {[FS_FIRST:FS_LAST]}) ?
                         {data_base[27:0], hex_val} : data_base;
          if (hpos_r == HDR_LAST) begin
            hpos_nxt = 7'd0;
            off_nxt  = HDR_OFFSET;
            idx_nxt  = 4'd0;
            if (name_len_r == 32'd0) begin
              tmatch_nxt = 1'b0;
              if (2'd0 - HDR_OFFSET != 2'd0) begin
                phase_nxt = PH_NAME_PAD;
                left_nxt  = {30'd0, 2'd0 - HDR_OFFSET};
              end else begin
                start_data = 1'b1;
              end
            end else begin
              tmatch_nxt = 1'b1;
              phase_nxt  = PH_NAME;
              left_nxt   = name_len_r;
            end
          end else begin
            hpos_nxt = hpos_r + 7'd1;
          end
        end
        PH_NAME: begin
          if (trailer_end) begin
            phase_nxt = PH_DONE;
          end else begin
            left_nxt = left_dec;
            off_nxt  = off_inc;
            if (idx_r < TRAILER_LEN) begin
              idx_nxt = idx_r + 4'd1;
            end
            if (tmatch_r) begin
              tmatch_nxt = (idx_r < TRAILER_LEN) && (b == trailer_char(idx_r));
            end
            if (last_byte) begin
              tmatch_nxt = 1'b0;
              if (pad_after != 2'd0) begin
                phase_nxt = PH_NAME_PAD;
                left_nxt  = 32'(pad_after);
              end else begin
                start_data = 1'b1;
              end
            end
          end
        end
        PH_NAME_PAD: begin
          left_nxt = left_dec;
          off_nxt  = off_inc;
          if (last_byte) begin
            start_data = 1'b1;
          end
        end
        PH_DATA: begin
          left_nxt = left_dec;
          off_nxt  = off_inc;
          if (last_byte) begin
            if (pad_after != 2'd0) begin
              phase_nxt = PH_DATA_PAD;
              left_nxt  = 32'(pad_after);
            end else begin
              finish_entry = 1'b1;
            end
          end
        end
        PH_DATA_PAD: begin
          left_nxt = left_dec;
          off_nxt  = off_inc;
          if (last_byte) begin
            finish_entry = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (start_data) begin
        if (data_len_nxt == 32'd0) begin
          finish_entry = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
          left_nxt  = data_len_nxt;
        end
      end
      if (finish_entry) begin
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        phase_nxt = PH_HEADER;
        hpos_nxt  = 7'd0;
        left_nxt  = 32'd0;
      end
    end
  end

  always_comb begin : outputs
    res_valid         = 1'b0;
    res.kind          = KIND_NAME;
    res.byte_value    = b;
    res.entry_number  = cnt_wide[15:0];
    res.file_size     = data_len_r;
    res.last_of_field = last_byte;
    case (phase_r)
      PH_NAME: begin
        res_valid = 1'b1;
        if (trailer_end) begin
          res.kind          = KIND_END;
          res.byte_value    = 8'd0;
          res.last_of_field = 1'b0;
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        res.kind  = KIND_DATA;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hpos_r     <= 7'd0;
      name_len_r <= 32'd0;
      data_len_r <= 32'd0;
      left_r     <= 32'd0;
      off_r      <= 2'd0;
      tmatch_r   <= 1'b1;
      idx_r      <= 4'd0;
      cnt_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hpos_r     <= hpos_nxt;
      name_len_r <= name_len_nxt;
      data_len_r <= data_len_nxt;
      left_r     <= left_nxt;
      off_r      <= off_nxt;
      tmatch_r   <= tmatch_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cnd_out_stage.sv -----
// Result register that holds one output beat until it is taken.
`default_nettype none
module cnd_out_stage import cnd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       space,
  cnd_res_if.source  out_bus
);

  logic valid_r;
  res_t res_r;

  assign space                 = !valid_r || out_bus.ready;
  assign out_bus.valid         = valid_r;
  assign out_bus.kind          = res_r.kind;
  assign out_bus.byte_value    = res_r.byte_value;
  assign out_bus.entry_number  = res_r.entry_number;
  assign out_bus.file_size     = res_r.file_size;
  assign out_bus.last_of_field = res_r.last_of_field;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cpio_newc_stream_deframer.sv -----
// Top level of the cpio newc stream deframer.
// Accepts one archive byte per cycle while the result side is not stalled; each
// byte passes an input register, the header/field logic and a result register
// before its name or data beat is valid on the result port. Header, padding and
// post-trailer bytes produce no beat. The single per-byte state update in the
// parser sets the rate; back-pressure on the result side stalls the input only
// once both registers are full. After the trailer name is seen one end beat is
// sent and all further bytes are dropped until reset.
`default_nettype none
module cpio_newc_stream_deframer import cnd_pkg::*; #(
  parameter int unsigned ENTRY_COUNT_BITS = ENTRY_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cnd_byte_if.sink   in_bus,
  cnd_res_if.source  out_bus
);

  logic       byte_valid;
  logic [7:0] byte_val;
  logic       space;
  logic       fire;
  logic       res_valid;
  res_t       res;

  assign fire = byte_valid && space;

  cnd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (fire),
    .byte_valid (byte_valid),
    .byte_val   (byte_val)
  );

  cnd_parse #(
    .ENTRY_COUNT_BITS (ENTRY_COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .b         (byte_val),
    .res_valid (res_valid),
    .res       (res)
  );

  cnd_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (fire && res_valid),
    .res     (res),
    .space   (space),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire

// ----- sv/cnd_checker.sv -----
// Port-level checks of the deframer and their binding to the top level.
`default_nettype none
module cnd_checker import cnd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  byte_value,
  input logic [15:0] entry_number,
  input logic [31:0] file_size,
  input logic        last_of_field
);

  logic end_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_seen_r <= 1'b0;
    end else if (out_valid && out_ready && kind == KIND_END) begin
      end_seen_r <= 1'b1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result beat dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(kind) && $stable(byte_value) &&
      $stable(entry_number) && $stable(file_size) && $stable(last_of_field))
    else $error("stalled result beat changed");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_END |-> byte_value == 8'd0 && !last_of_field)
    else $error("end beat carries byte or last flag");

  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_seen_r |-> !out_valid)
    else $error("result beat after end of archive");

endmodule

bind cpio_newc_stream_deframer cnd_checker u_cnd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .kind          (out_bus.kind),
  .byte_value    (out_bus.byte_value),
  .entry_number  (out_bus.entry_number),
  .file_size     (out_bus.file_size),
  .last_of_field (out_bus.last_of_field)
);
`default_nettype wire

// ----- tb/sv/cpio_newc_stream_deframer_tb.sv -----
// Testbench for the cpio newc stream deframer: directed entries, random archives, end check.
`timescale 1ns / 1ps
module cpio_newc_stream_deframer_tb;
  import cnd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 100;
  localparam int TAIL_BYTES   = 24;
  localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";

  typedef enum int {DIG_UPPER, DIG_LOWER, DIG_JUNK, DIG_MIXED} digit_style_e;

  typedef struct {
    string        text;
    int unsigned  name_size;
    int unsigned  data_size;
    digit_style_e style;
    logic [7:0]   fill;
    bit           typed;
    res_t         first_beat;
  } entry_row_t;

  entry_row_t plan [5] = '{
    '{"a",           1,  0, DIG_UPPER, 8'h00, 1'b1, '{KIND_NAME, 8'h61, 16'd0, 32'd0, 1'b1}},
    '{"",            0,  3, DIG_LOWER, 8'h00, 1'b0, '0},
    '{"",            3,  1, DIG_MIXED, 8'hFF, 1'b1, '{KIND_NAME, 8'hFF, 16'd2, 32'd1, 1'b0}},
    '{"",            2,  4, DIG_JUNK,  8'h00, 1'b1, '{KIND_NAME, 8'h00, 16'd3, 32'd4, 1'b0}},
    '{"TRAILER!!!x", 11, 5, DIG_LOWER, 8'h00, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  cnd_byte_if in_bus ();
  cnd_res_if  out_bus ();

  cpio_newc_stream_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // parser copy
  phase_t      prs_phase = PH_HEADER;
  logic [6:0]  hdr_pos   = '0;
  logic [31:0] name_len  = '0;
  logic [31:0] file_len  = '0;
  logic [31:0] left      = '0;
  logic [1:0]  ofs4      = '0;
  logic        trl_ok    = 1'b1;
  logic [15:0] entries   = '0;

  res_t       deframed_beats [$];
  logic [7:0] archive_bytes [$];
  res_t       override_beat;
  bit         override_armed;

  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_go;
  bit hold_active;
  int cycle_count;
  int mismatch_count;
  int bytes_taken;
  int name_beats;
  int data_beats;
  int end_beats;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycle_count,
               deframed_beats.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= "0" && c <= "9") begin
      n = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      n = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      n = 4'(c - "a" + 8'd10);
    end
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input digit_style_e st);
    logic [7:0] c;
    logic       upper;
    upper = (st == DIG_UPPER) || (st != DIG_LOWER && $urandom_range(1) == 1);
    if (n == 4'd0 && st == DIG_JUNK) begin
      do
        c = 8'($urandom_range(255));
      while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
    end else if (n < 4'd10) begin
      c = 8'("0" + n);
    end else begin
      c = 8'((upper ? "A" : "a") + n - 4'd10);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  task automatic push_beat(input logic [1:0] k, input logic [7:0] v, input logic last);
    res_t r;
    r = '{k, v, entries, file_len, last};
    if (override_armed) begin
      r = override_beat;
      override_armed = 1'b0;
    end
    deframed_beats.push_back(r);
  endtask

  task automatic close_entry();
    if (entries != 16'hFFFF) entries++;
    prs_phase = PH_HEADER;
    hdr_pos = '0;
    left = '0;
  endtask

  task automatic open_data();
    if (file_len == 0) begin
      close_entry();
    end else begin
      prs_phase = PH_DATA;
      left = file_len;
    end
  endtask

  task automatic close_name();
    if (ofs4 != 2'd0) begin
      prs_phase = PH_NAME_PAD;
      left = {30'd0, 2'd0 - ofs4};
    end else begin
      open_data();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [31:0] pos;
    case (prs_phase)
      PH_HEADER: begin
        if (hdr_pos == 7'd0) begin
          name_len = '0;
          file_len = '0;
        end
        if (hdr_pos >= FS_FIRST && hdr_pos <= FS_LAST) file_len = {file_len[27:0], nibble_of(b)};
        if (hdr_pos >= NS_FIRST && hdr_pos <= NS_LAST) name_len = {name_len[27:0], nibble_of(b)};
        if (hdr_pos == HDR_LAST) begin
          hdr_pos = '0;
          ofs4 = HDR_OFFSET;
          trl_ok = 1'b1;
          if (name_len == 0) begin
            trl_ok = 1'b0;
            close_name();
          end else begin
            prs_phase = PH_NAME;
            left = name_len;
          end
        end else begin
          hdr_pos = hdr_pos + 7'd1;
        end
      end
      PH_NAME: begin
        pos = name_len - left;
        left = left - 1;
        ofs4 = ofs4 + 2'd1;
        if (trl_ok && pos == 32'(TRAILER_LEN) && b == 8'h00) begin
          prs_phase = PH_DONE;
          push_beat(KIND_END, 8'h00, 1'b0);
        end else begin
          if (trl_ok) begin
            if (pos >= 32'(TRAILER_LEN)) trl_ok = 1'b0;
            else if (b != TRAILER_TEXT[79 - 8 * pos -: 8]) trl_ok = 1'b0;
          end
          push_beat(KIND_NAME, b, left == 0);
          if (left == 0) begin
            trl_ok = 1'b0;
            close_name();
          end
        end
      end
      PH_NAME_PAD: begin
        ofs4 = ofs4 + 2'd1;
        left = left - 1;
        if (left == 0) open_data();
      end
      PH_DATA: begin
        left = left - 1;
        ofs4 = ofs4 + 2'd1;
        push_beat(KIND_DATA, b, left == 0);
        if (left == 0) begin
          if (ofs4 != 2'd0) begin
            prs_phase = PH_DATA_PAD;
            left = {30'd0, 2'd0 - ofs4};
          end else begin
            close_entry();
          end
        end
      end
      PH_DATA_PAD: begin
        ofs4 = ofs4 + 2'd1;
        left = left - 1;
        if (left == 0) close_entry();
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_header(input logic [31:0] nsz, input logic [31:0] fsz,
                              input digit_style_e st);
    logic [7:0] c;
    for (int unsigned i = 0; i < HEADER_BYTES; i++) begin
      if (i >= FS_FIRST && i <= FS_LAST) c = hex_char(4'(fsz >> (4 * (FS_LAST - i))), st);
      else if (i >= NS_FIRST && i <= NS_LAST) c = hex_char(4'(nsz >> (4 * (NS_LAST - i))), st);
      else c = 8'($urandom_range(255));
      archive_bytes.push_back(c);
    end
  endtask

  task automatic queue_entry(input string text, input int unsigned nsz, input int unsigned fsz,
                             input digit_style_e st, input logic [7:0] fill, input bit scramble);
    queue_header(nsz, fsz, st);
    for (int unsigned i = 0; i < nsz; i++) begin
      if (i < text.len()) archive_bytes.push_back(text[i]);
      else if (scramble) archive_bytes.push_back(8'($urandom_range(255, 1)));
      else archive_bytes.push_back(fill);
    end
    repeat ((4 - (HEADER_BYTES + nsz) % 4) % 4) archive_bytes.push_back(8'($urandom_range(255)));
    repeat (fsz) archive_bytes.push_back(8'($urandom_range(255)));
    repeat ((4 - fsz % 4) % 4) archive_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.archive_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    bytes_taken++;
    deframe_byte(b);
  endtask

  task automatic drain_stream();
    while (archive_bytes.size() > 0) send_byte(archive_bytes.pop_front());
  endtask

  task automatic random_entry();
    int unsigned  sel;
    int unsigned  nsz;
    int unsigned  fsz;
    string        text;
    digit_style_e st;
    text = "";
    sel = $urandom_range(99);
    if (sel < 6) begin
      nsz = 0;
    end else if (sel < 16) begin
      text = "TRAILER!!!";
      nsz = $urandom_range(14, 6);
    end else begin
      nsz = $urandom_range(24, 1);
    end
    sel = $urandom_range(99);
    if (sel < 10) fsz = 0;
    else if (sel < 95) fsz = $urandom_range(48, 1);
    else fsz = $urandom_range(160, 49);
    st = digit_style_e'($urandom_range(3));
    queue_entry(text, nsz, fsz, st, 8'h00, 1'b1);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int taken;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    taken = 0;
    while (taken < PHASE_BYTES) begin
      random_entry();
      taken += archive_bytes.size();
      drain_stream();
    end
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_active) out_bus.ready <= 1'b0;
      else out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    hold_active = 1'b0;
    wait (hold_go);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (deframed_beats.size() == 0) begin
        report_mismatch($sformatf("beat with nothing pending: kind %0d byte %02h",
                                  out_bus.kind, out_bus.byte_value));
      end else begin
        want = deframed_beats.pop_front();
        if (out_bus.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_bus.kind, want.kind));
        if (out_bus.byte_value !== want.byte_value)
          report_mismatch($sformatf("byte_value %02h, want %02h", out_bus.byte_value,
                                    want.byte_value));
        if (out_bus.entry_number !== want.entry_number)
          report_mismatch($sformatf("entry_number %0d, want %0d", out_bus.entry_number,
                                    want.entry_number));
        if (out_bus.file_size !== want.file_size)
          report_mismatch($sformatf("file_size %08h, want %08h", out_bus.file_size,
                                    want.file_size));
        if (out_bus.last_of_field !== want.last_of_field)
          report_mismatch($sformatf("last_of_field %0b, want %0b", out_bus.last_of_field,
                                    want.last_of_field));
        case (want.kind)
          KIND_NAME: name_beats++;
          KIND_DATA: data_beats++;
          default:   end_beats++;
        endcase
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.archive_byte <= 8'h00;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hold the result side as the directed entries start to stream in
    hold_go = 1'b1;
    foreach (plan[i]) begin
      override_armed = plan[i].typed;
      override_beat = plan[i].first_beat;
      queue_entry(plan[i].text, plan[i].name_size, plan[i].data_size, plan[i].style,
                  plan[i].fill, 1'b0);
      drain_stream();
    end

    run_phase(83, 0);
    run_phase(0, 83);
    run_phase(25, 25);

    queue_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, DIG_LOWER);
    for (int k = 0; k < 10; k++) archive_bytes.push_back(TRAILER_TEXT[79 - 8 * k -: 8]);
    archive_bytes.push_back(8'h00);
    repeat (TAIL_BYTES) archive_bytes.push_back(8'($urandom_range(255)));
    drain_stream();
    in_bus.valid <= 1'b0;

    while (deframed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d archive bytes over %0d entries; beats: %0d name, %0d data, %0d end",
             bytes_taken, entries, name_beats, data_beats, end_beats);
    $display("idle mixes: none, sender, receiver, both; long receiver hold-off with stall");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cnd_pkg.sv
sv/cnd_stream_if.sv
sv/cnd_in_stage.sv
sv/cnd_parse.sv
sv/cnd_out_stage.sv
sv/cpio_newc_stream_deframer.sv
sv/cnd_checker.sv
tb/sv/cpio_newc_stream_deframer_tb.sv
